@@ hw/rtl/ght_pkg.sv @@
// ============================================================================
// ght_pkg - shared constants, types and a function for the Guo-Hall pass
// Frame limits, window geometry, config register indexes and the 3x3
// removal rule used by the thinning datapath.
// ============================================================================
package ght_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int POS_W       = $clog2(MAX_WIDTH * (MAX_HEIGHT + 1) + 1);

    localparam int WIN_ROWS    = 3;
    localparam int WIN_COLS    = 3;
    localparam int WIN_BITS    = WIN_ROWS * WIN_COLS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 3);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_PASS     = 2'd2;

    // per-transaction control carried down the pipeline
    typedef struct packed {
        logic has_res;
        logic last;
        logic interior;
        logic clear;
    } t_stage_ctl;

    typedef struct packed {
        logic pixel;
        logic removed;
        logic last;
    } t_result;

    // window layout: bits 0..2 top row, 3..5 middle row, 6..8 bottom row,
    // west to east within a row
    function automatic logic thin_remove(input logic [WIN_BITS-1:0] w, input logic odd);
        logic p1, p2, p3, p4, p5, p6, p7, p8, ctr;
        logic [2:0] c, n1, n2, n;
        logic m;
        p1  = w[0]; p2 = w[1]; p3 = w[2];
        p8  = w[3]; ctr = w[4]; p4 = w[5];
        p7  = w[6]; p6 = w[7]; p5 = w[8];
        c   = 3'(~p2 & (p3 | p4)) + 3'(~p4 & (p5 | p6))
            + 3'(~p6 & (p7 | p8)) + 3'(~p8 & (p1 | p2));
        n1  = 3'(p1 | p2) + 3'(p3 | p4) + 3'(p5 | p6) + 3'(p7 | p8);
        n2  = 3'(p2 | p3) + 3'(p4 | p5) + 3'(p6 | p7) + 3'(p8 | p1);
        n   = (n1 < n2) ? n1 : n2;
        m   = odd ? ((p2 | p3 | ~p5) & p4) : ((p6 | p7 | ~p1) & p8);
        return ctr && (c == 3'd1) && (n >= 3'd2) && (n <= 3'd3) && !m;
    endfunction

endpackage

@@ hw/rtl/ght_col_cell.sv @@
// ============================================================================
// ght_col_cell - one column of the 3x3 window
// Holds three vertically stacked pixels and takes its east neighbor's
// column on each shift; a pending frame restart loads zeros instead.
// ============================================================================
module ght_col_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic                          i_clear,
    input  logic [ght_pkg::WIN_ROWS-1:0]  i_d,
    output logic [ght_pkg::WIN_ROWS-1:0]  o_q
);

    logic [ght_pkg::WIN_ROWS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_clear ? '0 : i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/ght_line_buf.sv @@
// ============================================================================
// ght_line_buf - upper and middle line stores
// One word per column: bit 1 upper line, bit 0 middle line. Registered
// read; the write in the following cycle moves middle to upper and stores the pixel.
// ============================================================================
module ght_line_buf (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [ght_pkg::COL_W-1:0]  i_rd_addr,
    output logic                       o_up,
    output logic                       o_mid,
    input  logic                       i_wr_en,
    input  logic [ght_pkg::COL_W-1:0]  i_wr_addr,
    input  logic                       i_wr_px
);

    logic [1:0] r_mem [ght_pkg::MAX_WIDTH];
    logic [1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // write data uses the word read for the same column in the previous cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {r_rd[0], i_wr_px};
        end
    end

    assign o_up  = r_rd[1];
    assign o_mid = r_rd[0];

endmodule

@@ hw/rtl/guo_hall_thinning_pass.sv @@
// ============================================================================
// guo_hall_thinning_pass - one Guo-Hall thinning sub-iteration on a stream
// Raster pixels in, thinned pixels out W+1 transactions later; a chain of
// three window column cells fed from two line stores, a result queue out.
// ============================================================================
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | i_in_valid o_in_stall i_pixel_in i_is_padding | into block
//  out     | o_out_valid i_out_stall o_pixel_out o_was_removed o_frame_last | out
//  cfg     | i_cfg_we i_cfg_index i_cfg_data           | into block
//
//  One input transaction per clock while the input is not stalled. A result
//  becomes visible after the line store read, the window shift and the queue
//  write. The input stalls when four transactions are in flight or queued, and for
//  one cycle after a config write while the frame end position is recomputed.
//  Synchronous active-low reset clears counters, window and queue; the line
//  stores are not cleared, their stale contents only reach border pixels.
//
module guo_hall_thinning_pass (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_pixel_in,
    input  logic                           i_is_padding,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_pixel_out,
    output logic                           o_was_removed,
    output logic                           o_frame_last,
    input  logic                           i_cfg_we,
    input  logic [ght_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ght_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CW  = ght_pkg::CFG_W;
    localparam int PW  = ght_pkg::POS_W;
    localparam int RW  = ght_pkg::ROW_W;
    localparam int KW  = ght_pkg::COL_W;
    localparam int QD  = ght_pkg::QUEUE_DEPTH;
    localparam int QCW = ght_pkg::QCNT_W;
    localparam int NC  = ght_pkg::WIN_COLS;
    localparam int PRODW = 2 * CW + 1;

    function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v,
                                                input logic [CW-1:0] hi);
        if (v < CW'(3)) begin
            return CW'(3);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // ---------------- configuration ----------------
    logic [CW-1:0]    r_w;
    logic [CW-1:0]    r_h;
    logic             r_odd;
    logic             r_cfg_busy;
    logic [PW-1:0]    r_end;
    logic [PRODW-1:0] w_end_prod;

    assign w_end_prod = PRODW'(r_w) * (PRODW'(r_h) + PRODW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= CW'(ght_pkg::MAX_WIDTH);
            r_h        <= CW'(ght_pkg::MAX_HEIGHT);
            r_odd      <= 1'b0;
            r_cfg_busy <= 1'b0;
            r_end      <= PW'(ght_pkg::MAX_WIDTH * (ght_pkg::MAX_HEIGHT + 1));
        end else begin
            r_cfg_busy <= i_cfg_we;
            r_end      <= w_end_prod[PW-1:0];
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ght_pkg::REG_IMAGE_WIDTH:
                        r_w <= clamp_dim(i_cfg_data, CW'(ght_pkg::MAX_WIDTH));
                    ght_pkg::REG_IMAGE_HEIGHT:
                        r_h <= clamp_dim(i_cfg_data, CW'(ght_pkg::MAX_HEIGHT));
                    ght_pkg::REG_ODD_PASS:
                        r_odd <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- raster position ----------------
    logic [PW-1:0]   r_pos;
    logic [KW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            w_in_acc;
    logic            w_wrap0;
    logic            w_wrap1;
    logic [KW-1:0]   w_cc;
    logic [CW-1:0]   w_cc_inc;
    logic [RW-1:0]   w_rowc;
    logic            w_done;
    logic            w_px;
    ght_pkg::t_stage_ctl w_ctl;

    logic               r_a_valid;
    logic               r_a_px;
    logic [KW-1:0]      r_a_addr;
    ght_pkg::t_stage_ctl r_a_ctl;
    logic               r_b_valid;
    ght_pkg::t_stage_ctl r_b_ctl;

    logic [QCW-1:0] r_q_cnt;
    logic [QCW-1:0] w_inflight;

    assign w_inflight = QCW'(r_a_valid) + QCW'(r_b_valid) + r_q_cnt;
    assign o_in_stall = r_cfg_busy || (w_inflight >= QCW'(QD));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // a column count left at or past the width wraps before use
    assign w_wrap0  = CW'(r_col) >= r_w;
    assign w_cc     = w_wrap0 ? '0 : r_col;
    assign w_rowc   = w_wrap0 ? r_row + RW'(1) : r_row;
    assign w_cc_inc = CW'(w_cc) + CW'(1);
    assign w_wrap1  = w_cc_inc >= r_w;
    assign w_done   = r_pos >= r_end;
    assign w_px     = i_pixel_in & ~i_is_padding;

    // the centre sits one column left of w_cc; column 0 centres are borders
    assign w_ctl.interior = (w_cc >= KW'(2)) && (w_rowc >= RW'(2)) && (w_rowc < RW'(r_h));
    assign w_ctl.has_res  = (r_pos >= PW'(r_w) + PW'(1)) && (r_pos <= r_end);
    assign w_ctl.last     = r_pos == r_end;
    assign w_ctl.clear    = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_acc) begin
            if (w_done) begin
                r_pos <= '0;
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_pos <= r_pos + PW'(1);
                r_col <= w_wrap1 ? '0 : w_cc_inc[KW-1:0];
                r_row <= w_wrap1 ? w_rowc + RW'(1) : w_rowc;
            end
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_in_acc;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_px   <= w_px;
            r_a_addr <= w_cc;
            r_a_ctl  <= w_ctl;
        end
        if (r_a_valid) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    // ---------------- line stores ----------------
    logic w_up;
    logic w_mid;

    ght_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_cc),
        .o_up      (w_up),
        .o_mid     (w_mid),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_addr),
        .i_wr_px   (r_a_px)
    );

    // ---------------- window cell chain ----------------
    logic                           r_win_clr;
    logic [ght_pkg::WIN_ROWS-1:0]   w_new_col;
    logic [ght_pkg::WIN_ROWS-1:0]   w_col [NC];
    logic [ght_pkg::WIN_BITS-1:0]   w_win;

    assign w_new_col = {r_a_px, w_mid, w_up};

    // frame restart zeroes the two older window columns just before the next shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_clr <= 1'b0;
        end else if (r_a_valid) begin
            r_win_clr <= r_a_ctl.clear;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cell
        if (k == NC - 1) begin : g_head
            ght_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (r_a_valid),
                .i_clear (1'b0),
                .i_d     (w_new_col),
                .o_q     (w_col[k])
            );
        end else begin : g_body
            ght_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (r_a_valid),
                .i_clear (r_win_clr),
                .i_d     (w_col[k+1]),
                .o_q     (w_col[k])
            );
        end
    end

    assign w_win = {w_col[2][2], w_col[1][2], w_col[0][2],
                    w_col[2][1], w_col[1][1], w_col[0][1],
                    w_col[2][0], w_col[1][0], w_col[0][0]};

    // ---------------- decision and result queue ----------------
    logic                  w_rem;
    logic                  w_push;
    logic                  w_pop;
    ght_pkg::t_result      w_res;
    ght_pkg::t_result      r_q [QD];
    logic [ght_pkg::QPTR_W-1:0] r_q_wp;
    logic [ght_pkg::QPTR_W-1:0] r_q_rp;

    assign w_rem       = r_b_ctl.interior && ght_pkg::thin_remove(w_win, r_odd);
    assign w_res.pixel   = w_win[4] & ~w_rem;
    assign w_res.removed = w_rem;
    assign w_res.last    = r_b_ctl.last;
    assign w_push      = r_b_valid && r_b_ctl.has_res;
    assign w_pop       = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q_wp <= r_q_wp + 1'b1;
            end
            if (w_pop) begin
                r_q_rp <= r_q_rp + 1'b1;
            end
            r_q_cnt <= r_q_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_q_wp] <= w_res;
        end
    end

    assign o_out_valid   = r_q_cnt != '0;
    assign o_pixel_out   = r_q[r_q_rp].pixel;
    assign o_was_removed = r_q[r_q_rp].removed;
    assign o_frame_last  = r_q[r_q_rp].last;

    // ---------------- assertions ----------------
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= QCW'(QD))
        else $error("result queue count out of range");

    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (r_q_cnt < QCW'(QD)))
        else $error("result pushed into full queue");

    a_cfg_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg_busy |-> !w_in_acc)
        else $error("transaction accepted right after config write");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_done) |=> (r_pos == '0 && r_col == '0 && r_row == '0))
        else $error("counters not cleared at frame end");

    a_removed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_removed) |-> !o_pixel_out)
        else $error("removed pixel still set");

endmodule
